// File: design/tea_block_encrypt_macros.svh
// ----------------------------------------------------------------------------
// tea_block_encrypt_macros.svh
// Assertion helper macros for the TEA block encryptor.
// ----------------------------------------------------------------------------
`ifndef TEA_BLOCK_ENCRYPT_MACROS_SVH
`define TEA_BLOCK_ENCRYPT_MACROS_SVH

// same-cycle implication, masked during reset
`define TEA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tea_block_encrypt: same-cycle check failed");

// next-cycle implication, masked during reset
`define TEA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tea_block_encrypt: next-cycle check failed");

`endif

// File: design/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Types and constants shared by the TEA block encryptor.
// ----------------------------------------------------------------------------
package tea_pkg;

    localparam int WORD_W  = 32;
    localparam int ROUND_W = 13;
    localparam int CFG_IDX_W = 3;

    localparam logic [WORD_W-1:0] TEA_DELTA = 32'h9e37_79b9;

    // register map
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ROUND_COUNT = 3'd4;

    // reset values
    localparam logic [WORD_W-1:0]  KEY_WORD0_RST   = 32'h0123_4567;
    localparam logic [WORD_W-1:0]  KEY_WORD1_RST   = 32'h89ab_cdef;
    localparam logic [WORD_W-1:0]  KEY_WORD2_RST   = 32'h1357_9248;
    localparam logic [WORD_W-1:0]  KEY_WORD3_RST   = 32'h248a_0135;
    localparam logic [ROUND_W-1:0] ROUND_COUNT_RST = 13'd1024;

    typedef struct packed {
        logic [WORD_W-1:0] plain_word0;
        logic [WORD_W-1:0] plain_word1;
    } in_data_t;

    typedef struct packed {
        logic [WORD_W-1:0] cipher_word0;
        logic [WORD_W-1:0] cipher_word1;
    } out_data_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

endpackage

// File: design/tea_block_encrypt.sv
// ----------------------------------------------------------------------------
// tea_block_encrypt
// TEA block encryptor with a shared half-round mixing unit.
// ----------------------------------------------------------------------------
// One 64-bit block is taken per input transaction and encrypted over
// round_count rounds with the 128-bit key held in key_word0..3. A single
// mixing unit (shift/add/xor/add) computes one half-round per cycle, so
// each round is done as two half-rounds. After the last round the result
// is loaded into the output register, and the next block can be accepted
// in the cycle after the load; no new block is taken while one is in
// flight. The load
// is held off while the output register still holds an unaccepted result.
// in_ready is high only while no block is in flight; a finished result may
// wait in the output register while the next block is already being
// encrypted. Configuration writes are always accepted and must only be
// issued while the block is idle.
`include "tea_block_encrypt_macros.svh"

module tea_block_encrypt (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  tea_pkg::in_data_t                   in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output tea_pkg::out_data_t                  out_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [tea_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [tea_pkg::WORD_W-1:0]          cfg_data
);
    import tea_pkg::*;

    state_t               state_reg, state_next;
    logic                 phase_reg, phase_next;
    logic [ROUND_W-1:0]   rounds_left_reg, rounds_left_next;
    logic [WORD_W-1:0]    w0_reg, w0_next;
    logic [WORD_W-1:0]    w1_reg, w1_next;
    logic [WORD_W-1:0]    sum_reg, sum_next;
    logic                 out_valid_reg, out_valid_next;
    out_data_t            out_data_reg, out_data_next;

    logic [WORD_W-1:0]    key_word0_reg, key_word1_reg, key_word2_reg, key_word3_reg;
    logic [ROUND_W-1:0]   round_count_reg;

    logic [WORD_W-1:0]    mix_src, mix_ka, mix_kb, mix_tgt, mix_f, mix_out;
    logic                 in_fire, out_fire, out_free;

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_word0_reg   <= KEY_WORD0_RST;
            key_word1_reg   <= KEY_WORD1_RST;
            key_word2_reg   <= KEY_WORD2_RST;
            key_word3_reg   <= KEY_WORD3_RST;
            round_count_reg <= ROUND_COUNT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_WORD0:   key_word0_reg   <= cfg_data;
                REG_KEY_WORD1:   key_word1_reg   <= cfg_data;
                REG_KEY_WORD2:   key_word2_reg   <= cfg_data;
                REG_KEY_WORD3:   key_word3_reg   <= cfg_data;
                REG_ROUND_COUNT: round_count_reg <= cfg_data[ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    // shared half-round unit: phase 0 updates word 0 from word 1,
    // phase 1 updates word 1 from the new word 0
    always_comb
    begin
        mix_src = phase_reg ? w0_reg        : w1_reg;
        mix_ka  = phase_reg ? key_word2_reg : key_word0_reg;
        mix_kb  = phase_reg ? key_word3_reg : key_word1_reg;
        mix_tgt = phase_reg ? w1_reg        : w0_reg;
        mix_f   = ((mix_src << 4) + mix_ka) ^ (mix_src + sum_reg) ^ ((mix_src >> 5) + mix_kb);
        mix_out = mix_tgt + mix_f;
    end

    always_comb
    begin
        state_next       = state_reg;
        phase_next       = phase_reg;
        rounds_left_next = rounds_left_reg;
        w0_next          = w0_reg;
        w1_next          = w1_reg;
        sum_next         = sum_reg;
        out_valid_next   = out_fire ? 1'b0 : out_valid_reg;
        out_data_next    = out_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    w0_next          = in_data.plain_word0;
                    w1_next          = in_data.plain_word1;
                    sum_next         = TEA_DELTA;
                    phase_next       = 1'b0;
                    rounds_left_next = round_count_reg;
                    state_next       = (round_count_reg == '0) ? ST_DRAIN : ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (!phase_reg)
                begin
                    w0_next    = mix_out;
                    phase_next = 1'b1;
                end
                else
                begin
                    w1_next          = mix_out;
                    sum_next         = sum_reg + TEA_DELTA;
                    phase_next       = 1'b0;
                    rounds_left_next = rounds_left_reg - 1'b1;
                    if (rounds_left_reg == ROUND_W'(1))
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                // wait until the output register is free
                if (out_free)
                begin
                    out_valid_next             = 1'b1;
                    out_data_next.cipher_word0 = w0_reg;
                    out_data_next.cipher_word1 = w1_reg;
                    state_next                 = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            phase_reg       <= 1'b0;
            rounds_left_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            phase_reg       <= phase_next;
            rounds_left_reg <= rounds_left_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w0_reg       <= w0_next;
        w1_reg       <= w1_next;
        sum_reg      <= sum_next;
        out_data_reg <= out_data_next;
    end

    `TEA_ASSERT_NEXT(a_accept_starts, clk, rst_n, in_fire, state_reg != ST_IDLE)
    `TEA_ASSERT_SAME(a_run_has_rounds, clk, rst_n, state_reg == ST_RUN, rounds_left_reg != '0)
    `TEA_ASSERT_NEXT(a_drain_holds, clk, rst_n, state_reg == ST_DRAIN && !out_free, state_reg == ST_DRAIN)

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the TEA block encryptor.
// ----------------------------------------------------------------------------
// Plaintext blocks are queued by a sequencer and sent in random bursts.
// Each accepted block is enciphered by a bench-side copy of the cipher and
// the expected ciphertext is queued. Every output transaction is compared
// word by word with the oldest entry. Key and round-count settings change
// only between phases, once all ciphertext has come back. The settings
// include the reset values, zero rounds, 8191 rounds, all-zero and all-one
// keys, and writes to unused register indexes. The receiver stalls in
// modes of its own.
module tb_top;

    localparam logic [31:0] CIPHER_DELTA    = 32'h9e37_79b9;
    localparam logic [31:0] KEY0_DEFAULT    = 32'h0123_4567;
    localparam logic [31:0] KEY1_DEFAULT    = 32'h89ab_cdef;
    localparam logic [31:0] KEY2_DEFAULT    = 32'h1357_9248;
    localparam logic [31:0] KEY3_DEFAULT    = 32'h248a_0135;
    localparam logic [12:0] ROUNDS_DEFAULT  = 13'd1024;
    localparam int          STALL_LIMIT     = 100_000;
    localparam int          RAND_PHASES     = 12;
    localparam int          BLOCKS_PER_PHASE = 48;

    typedef enum logic [1:0] {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_HOLD} rx_mode_t;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    logic                in_ready;
    tea_pkg::in_data_t   in_data   = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    tea_pkg::out_data_t  out_data;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [tea_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tea_pkg::WORD_W-1:0]    cfg_data  = '0;

    // bench copy of the cipher registers
    logic [31:0] key_q [4] = '{KEY0_DEFAULT, KEY1_DEFAULT, KEY2_DEFAULT, KEY3_DEFAULT};
    logic [12:0] rounds_q  = ROUNDS_DEFAULT;

    tea_pkg::in_data_t  plain_pending [$];
    tea_pkg::out_data_t cipher_expected [$];

    int       burst_left = 0;
    int       gap_left   = 0;
    rx_mode_t rx_mode    = RX_OPEN;
    int       rx_left    = 0;
    int       idle_cycles = 0;
    int       errors = 0;
    int       blocks_sent = 0;
    int       blocks_checked = 0;
    int       settings_used = 1;

    tea_block_encrypt dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic tea_pkg::out_data_t encipher_block(tea_pkg::in_data_t blk);
        tea_pkg::out_data_t res;
        logic [31:0] v0;
        logic [31:0] v1;
        logic [31:0] acc;
        v0  = blk.plain_word0;
        v1  = blk.plain_word1;
        acc = '0;
        for (int n = 0; n < int'(rounds_q); n++)
        begin
            acc = acc + CIPHER_DELTA;
            v0 = v0 + (((v1 << 4) + key_q[0]) ^ (v1 + acc) ^ ((v1 >> 5) + key_q[1]));
            v1 = v1 + (((v0 << 4) + key_q[2]) ^ (v0 + acc) ^ ((v0 >> 5) + key_q[3]));
        end
        res.cipher_word0 = v0;
        res.cipher_word1 = v1;
        return res;
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 15))
            0:       return 32'h0000_0000;
            1:       return 32'hffff_ffff;
            default: return $urandom();
        endcase
    endfunction

    // block sender: bursts of random length, random gaps between them
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            in_data    <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (plain_pending.size() > 0)
            begin
                in_data  <= plain_pending.pop_front();
                in_valid <= 1'b1;
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 12);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ciphertext receiver: picks a random stall mode and re-picks it whenever its run counter runs out
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_mode   = RX_OPEN;
            rx_left   = 0;
        end
        else
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(16, 200);
            end
            else
                rx_left--;
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
                RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
                default:   out_ready <= 1'b0;
            endcase
        end
    end

    // monitor: register writes, block acceptance, ciphertext check, watchdog
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_q       = '{KEY0_DEFAULT, KEY1_DEFAULT, KEY2_DEFAULT, KEY3_DEFAULT};
            rounds_q    = ROUNDS_DEFAULT;
            idle_cycles = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tea_pkg::REG_KEY_WORD0:   key_q[0] = cfg_data;
                    tea_pkg::REG_KEY_WORD1:   key_q[1] = cfg_data;
                    tea_pkg::REG_KEY_WORD2:   key_q[2] = cfg_data;
                    tea_pkg::REG_KEY_WORD3:   key_q[3] = cfg_data;
                    tea_pkg::REG_ROUND_COUNT: rounds_q = cfg_data[tea_pkg::ROUND_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                cipher_expected.push_back(encipher_block(in_data));
                blocks_sent++;
            end
            if (out_valid && out_ready)
            begin
                if (cipher_expected.size() == 0)
                begin
                    $error("ciphertext transaction with none expected: %h", out_data);
                    errors++;
                end
                else
                begin
                    tea_pkg::out_data_t exp_blk;
                    exp_blk = cipher_expected.pop_front();
                    if (out_data.cipher_word0 !== exp_blk.cipher_word0)
                    begin
                        $error("cipher_word0 mismatch: expected %h, got %h",
                               exp_blk.cipher_word0, out_data.cipher_word0);
                        errors++;
                    end
                    if (out_data.cipher_word1 !== exp_blk.cipher_word1)
                    begin
                        $error("cipher_word1 mismatch: expected %h, got %h",
                               exp_blk.cipher_word1, out_data.cipher_word1);
                        errors++;
                    end
                    blocks_checked++;
                end
            end
            if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", idle_cycles);
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // caller must be at a rising edge; returns at the edge of acceptance
    task automatic write_reg(input logic [tea_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic apply_setting(input logic [31:0] k0, input logic [31:0] k1,
                                 input logic [31:0] k2, input logic [31:0] k3,
                                 input logic [31:0] rounds_raw, input bit unused_too);
        @(posedge clk);
        write_reg(tea_pkg::REG_KEY_WORD0, k0);
        write_reg(tea_pkg::REG_KEY_WORD1, k1);
        write_reg(tea_pkg::REG_KEY_WORD2, k2);
        write_reg(tea_pkg::REG_KEY_WORD3, k3);
        // indexes past the register map must be ignored
        if (unused_too)
            for (int idx = int'(tea_pkg::REG_ROUND_COUNT) + 1;
                 idx < (1 << tea_pkg::CFG_IDX_W); idx++)
                write_reg(tea_pkg::CFG_IDX_W'(idx), $urandom());
        write_reg(tea_pkg::REG_ROUND_COUNT, rounds_raw);
        cfg_valid <= 1'b0;
        @(negedge clk);
        settings_used++;
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (plain_pending.size() != 0 || in_valid || cipher_expected.size() != 0);
    endtask

    task automatic queue_block(input logic [31:0] w0, input logic [31:0] w1);
        tea_pkg::in_data_t blk;
        blk.plain_word0 = w0;
        blk.plain_word1 = w1;
        plain_pending.push_back(blk);
    endtask

    initial
    begin
        logic [31:0] rounds_raw;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset key and 1024 rounds
        queue_block(32'h0000_0000, 32'h0000_0000);
        queue_block(32'hffff_ffff, 32'hffff_ffff);
        queue_block(32'h0000_0000, 32'hffff_ffff);
        queue_block(32'hffff_ffff, 32'h0000_0000);
        queue_block(32'haaaa_aaaa, 32'h5555_5555);
        queue_block(32'h8000_0001, 32'h0000_0001);
        // wait until every ciphertext is back before changing settings
        wait_idle();

        // zero rounds: output equals input
        apply_setting(KEY0_DEFAULT, KEY1_DEFAULT, KEY2_DEFAULT, KEY3_DEFAULT, 32'h0, 1'b0);
        queue_block(32'h0123_4567, 32'h89ab_cdef);
        queue_block(32'hffff_ffff, 32'h0000_0000);
        queue_block($urandom(), $urandom());
        wait_idle();

        // zero key; upper bits of the round write must be masked (one round)
        apply_setting('0, '0, '0, '0, 32'hffff_e001, 1'b0);
        queue_block(32'h0000_0000, 32'h0000_0000);
        queue_block(32'hffff_ffff, 32'hffff_ffff);
        queue_block($urandom(), $urandom());
        wait_idle();

        // all-ones key, largest 13-bit round count, unused indexes written
        apply_setting('1, '1, '1, '1, 32'h0000_1fff, 1'b1);
        queue_block(32'hffff_ffff, 32'hffff_ffff);
        queue_block($urandom(), $urandom());
        wait_idle();

        apply_setting($urandom(), $urandom(), $urandom(), $urandom(), 32'd4096, 1'b0);
        queue_block(32'h0000_0000, 32'hffff_ffff);
        queue_block($urandom(), $urandom());

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            wait_idle();
            case ($urandom_range(0, 9))
                0:       rounds_raw = 32'd0;
                1:       rounds_raw = 32'd1;
                2:       rounds_raw = $urandom_range(100, 300);
                default: rounds_raw = $urandom_range(2, 32);
            endcase
            rounds_raw = ($urandom() & ~32'h1fff) | rounds_raw;
            apply_setting(rand_word(), rand_word(), rand_word(), rand_word(), rounds_raw,
                          ($urandom_range(0, 2) == 0));
            for (int i = 0; i < BLOCKS_PER_PHASE; i++)
                queue_block(rand_word(), rand_word());
        end

        wait_idle();
        // catch any stray ciphertext after the last expected one
        repeat (2 * int'(rounds_q) + 16) @(posedge clk);

        $display("%0d blocks sent, %0d ciphertexts checked, %0d key/round settings",
                 blocks_sent, blocks_checked, settings_used);
        $display("round counts 0, 1, 1024, 4096, 8191 and short random runs; bad indexes written");
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// File: tea_block_encrypt.f
+incdir+design
design/tea_pkg.sv
design/tea_block_encrypt.sv
bench/tb_top.sv
